/* sv/reqq_pkg.sv */
// shared types and constants for the rotary encoder event queue
// no dependencies; used by rotary_encoder_event_queue_core
package reqq_pkg;

   // queue geometry
   localparam int QUEUE_DEPTH = 8;
   localparam int QIDX_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int QSUM_W      = QIDX_W + 2;

   // field widths
   localparam int TIME_W  = 32;
   localparam int CFG_W   = 16;
   localparam int CODE_W  = 3;
   localparam int COUNT_W = 4;
   localparam int PUSH_N  = 3;

   // register reset values
   localparam logic [CFG_W-1:0] DEBOUNCE_RESET   = 16'd5;
   localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'd1000;

   typedef enum logic [CODE_W-1:0] {
      EV_CW       = 3'd0,
      EV_CCW      = 3'd1,
      EV_PRESSED  = 3'd2,
      EV_RELEASED = 3'd3,
      EV_LONG     = 3'd4
   } event_code_type;

   typedef enum logic {
      REQ_SAMPLE = 1'b0,
      REQ_POP    = 1'b1
   } req_kind_type;

   typedef enum logic {
      CSR_DEBOUNCE   = 1'b0,
      CSR_LONG_PRESS = 1'b1
   } csr_index_type;

   // pin positions in the level vectors
   localparam int PIN_CLK = 0;
   localparam int PIN_DT  = 1;
   localparam int PIN_SW  = 2;
   localparam int PIN_N   = 3;

endpackage

/* sv/rotary_encoder_event_queue_core.sv */
// rotary encoder debounce, button timing and event queue, top level
// depends on reqq_pkg
//
// Takes one word per cycle on req when unstalled. A sample word (req_type 0)
// debounces the CLK, DT and switch pins against req_now_ms and may queue up
// to three events (rotation first, then released and pressed, or a single
// long press); a pop word (req_type 1) returns the oldest queued event. Every
// word yields exactly one rsp word, carrying the queue fill after that word.
// Throughput is one word per clock unless stalled: the word is captured in
// an input register, all debounce, press timing and queue updates are worked
// out in one pass of shallow logic (four 32-bit subtract-and-compare units
// side by side) and the answer lands in an output register.
// A full queue drops new events silently. The csr port may be written only
// while no word is in flight.
module rotary_encoder_event_queue_core (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_type,
   input  logic                        req_clk_level,
   input  logic                        req_dt_level,
   input  logic                        req_sw_level,
   input  logic [reqq_pkg::TIME_W-1:0] req_now_ms,
   // response channel
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_event_valid,
   output logic [reqq_pkg::CODE_W-1:0] rsp_event_code,
   output logic [reqq_pkg::COUNT_W-1:0] rsp_queue_count,
   output logic                        rsp_queue_nonempty,
   // configuration
   input  logic                        csr_write,
   input  logic                        csr_index,
   input  logic [reqq_pkg::CFG_W-1:0]  csr_wdata
);

   localparam int TW = reqq_pkg::TIME_W;
   localparam int NP = reqq_pkg::PIN_N;

   // ---------------------------------------------------------------- config
   logic [reqq_pkg::CFG_W-1:0] debounce_ff, long_press_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff   <= reqq_pkg::DEBOUNCE_RESET;
         long_press_ff <= reqq_pkg::LONG_PRESS_RESET;
      end else if (csr_write) begin
         unique case (reqq_pkg::csr_index_type'(csr_index))
            reqq_pkg::CSR_DEBOUNCE:   debounce_ff   <= csr_wdata;
            reqq_pkg::CSR_LONG_PRESS: long_press_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ----------------------------------------------------------- input stage
   logic          in_valid_ff, in_valid_in;
   logic          in_kind_ff;
   logic [NP-1:0] in_active_ff;   // 1 = pin active (low)
   logic [TW-1:0] in_now_ff;

   logic out_free;   // output register can take a new word this cycle
   logic process;    // the held word is worked this cycle
   logic req_take;

   assign out_free  = !rsp_valid || !rsp_stall;
   assign process   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (process) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_kind_ff                    <= req_type;
         in_active_ff[reqq_pkg::PIN_CLK] <= !req_clk_level;
         in_active_ff[reqq_pkg::PIN_DT]  <= !req_dt_level;
         in_active_ff[reqq_pkg::PIN_SW]  <= !req_sw_level;
         in_now_ff                     <= req_now_ms;
      end
   end

   // ------------------------------------------------------- debounce state
   logic [NP-1:0] raw_ff, raw_in;
   logic [NP-1:0] stable_ff, stable_in;
   logic [TW-1:0] change_ff [NP];
   logic [TW-1:0] change_in [NP];
   logic [TW-1:0] press_start_ff, press_start_in;
   logic          armed_ff, armed_in;
   logic          fired_ff, fired_in;

   // ---------------------------------------------------------- queue state
   logic [reqq_pkg::CODE_W-1:0]  store_ff [reqq_pkg::QUEUE_DEPTH];
   logic [reqq_pkg::QIDX_W-1:0]  head_ff, head_in;
   logic [reqq_pkg::QFILL_W-1:0] fill_ff, fill_in;

   logic                          is_sample, is_pop;
   logic [TW-1:0]                 elapsed [NP];
   logic [TW-1:0]                 held_time;
   logic                          long_due;

   // candidate pushes in queue order: rotation, released or long, pressed
   logic [reqq_pkg::PUSH_N-1:0]  push_req;
   logic [reqq_pkg::CODE_W-1:0]  push_code [reqq_pkg::PUSH_N];
   logic [reqq_pkg::PUSH_N-1:0]  wr_en;
   logic [reqq_pkg::QIDX_W-1:0]  wr_slot [reqq_pkg::PUSH_N];
   logic [reqq_pkg::QFILL_W-1:0] run_fill [reqq_pkg::PUSH_N+1];
   logic [reqq_pkg::QSUM_W-1:0]  slot_sum [reqq_pkg::PUSH_N];

   logic                          pop_hit;
   logic [reqq_pkg::CODE_W-1:0]  pop_code;
   logic [reqq_pkg::QFILL_W+reqq_pkg::COUNT_W-1:0] fill_ext;

   assign is_sample = process && (in_kind_ff == reqq_pkg::REQ_SAMPLE);
   assign is_pop    = process && (in_kind_ff == reqq_pkg::REQ_POP);

   // per-pin debounce: a raw change restarts the pin timer
   always_comb begin
      for (int p = 0; p < NP; p++) begin
         raw_in[p]    = raw_ff[p];
         change_in[p] = change_ff[p];
         stable_in[p] = stable_ff[p];
         if (in_active_ff[p] != raw_ff[p]) begin
            raw_in[p]    = in_active_ff[p];
            change_in[p] = in_now_ff;
         end
         elapsed[p] = in_now_ff - change_in[p];
         if ((raw_in[p] != stable_ff[p]) &&
             (elapsed[p] >= {{(TW-reqq_pkg::CFG_W){1'b0}}, debounce_ff})) begin
            stable_in[p] = raw_in[p];
         end
      end
   end

   // rotation and button events
   assign held_time = in_now_ff - press_start_ff;
   assign long_due  = held_time >= {{(TW-reqq_pkg::CFG_W){1'b0}}, long_press_ff};

   always_comb begin
      push_req       = '0;
      push_code[0]   = reqq_pkg::EV_CW;
      push_code[1]   = reqq_pkg::EV_RELEASED;
      push_code[2]   = reqq_pkg::EV_PRESSED;
      press_start_in = press_start_ff;
      armed_in       = armed_ff;
      fired_in       = fired_ff;

      // clk going active: dt against clk picks the direction
      if (stable_in[reqq_pkg::PIN_CLK] && !stable_ff[reqq_pkg::PIN_CLK]) begin
         push_req[0]  = 1'b1;
         push_code[0] = (stable_in[reqq_pkg::PIN_DT] != stable_in[reqq_pkg::PIN_CLK])
                        ? reqq_pkg::EV_CW : reqq_pkg::EV_CCW;
      end

      priority if (stable_in[reqq_pkg::PIN_SW] != stable_ff[reqq_pkg::PIN_SW]) begin
         if (stable_in[reqq_pkg::PIN_SW]) begin
            press_start_in = in_now_ff;
            armed_in       = 1'b1;
            fired_in       = 1'b0;
         end else begin
            push_req[1]    = 1'b1;
            push_req[2]    = !fired_ff && armed_ff;
            fired_in       = 1'b0;
            armed_in       = 1'b0;
            press_start_in = '0;
         end
      end else if (stable_ff[reqq_pkg::PIN_SW] && !fired_ff && armed_ff && long_due) begin
         push_req[1]  = 1'b1;
         push_code[1] = reqq_pkg::EV_LONG;
         fired_in     = 1'b1;
      end else begin
         // nothing to do for the switch
      end
   end

   // slot allocation: each push lands after the ones before it, full drops
   always_comb begin
      run_fill[0] = fill_ff;
      for (int k = 0; k < reqq_pkg::PUSH_N; k++) begin
         wr_en[k]    = is_sample && push_req[k] &&
                       (run_fill[k] < reqq_pkg::QFILL_W'(reqq_pkg::QUEUE_DEPTH));
         slot_sum[k] = reqq_pkg::QSUM_W'(head_ff) + reqq_pkg::QSUM_W'(run_fill[k]);
         if (slot_sum[k] >= reqq_pkg::QSUM_W'(reqq_pkg::QUEUE_DEPTH)) begin
            slot_sum[k] = slot_sum[k] - reqq_pkg::QSUM_W'(reqq_pkg::QUEUE_DEPTH);
         end
         wr_slot[k]     = slot_sum[k][reqq_pkg::QIDX_W-1:0];
         run_fill[k+1]  = run_fill[k] + reqq_pkg::QFILL_W'(wr_en[k]);
      end
   end

   // pop and queue pointers
   assign pop_hit  = is_pop && (fill_ff != '0);
   assign pop_code = store_ff[head_ff];

   always_comb begin
      head_in = head_ff;
      fill_in = fill_ff;
      if (pop_hit) begin
         fill_in = fill_ff - 1'b1;
         if (head_ff == reqq_pkg::QIDX_W'(reqq_pkg::QUEUE_DEPTH - 1)) begin
            head_in = '0;
         end else begin
            head_in = head_ff + 1'b1;
         end
      end else if (is_sample) begin
         fill_in = run_fill[reqq_pkg::PUSH_N];
      end
   end

   assign fill_ext = {{reqq_pkg::COUNT_W{1'b0}}, fill_in};

   always_ff @(posedge clock) begin
      for (int k = 0; k < reqq_pkg::PUSH_N; k++) begin
         if (wr_en[k]) begin
            store_ff[wr_slot[k]] <= push_code[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_ff         <= '0;
         stable_ff      <= '0;
         for (int p = 0; p < NP; p++) begin
            change_ff[p] <= '0;
         end
         press_start_ff <= '0;
         armed_ff       <= 1'b0;
         fired_ff       <= 1'b0;
         head_ff        <= '0;
         fill_ff        <= '0;
      end else begin
         if (is_sample) begin
            raw_ff         <= raw_in;
            stable_ff      <= stable_in;
            for (int p = 0; p < NP; p++) begin
               change_ff[p] <= change_in[p];
            end
            press_start_ff <= press_start_in;
            armed_ff       <= armed_in;
            fired_ff       <= fired_in;
         end
         if (process) begin
            head_ff <= head_in;
            fill_ff <= fill_in;
         end
      end
   end

   // ---------------------------------------------------------- output stage
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_event_valid_ff;
   logic [reqq_pkg::CODE_W-1:0]  rsp_code_ff;
   logic [reqq_pkg::COUNT_W-1:0] rsp_count_ff;
   logic                         rsp_nonempty_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (process) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (process) begin
         rsp_event_valid_ff <= pop_hit;
         rsp_code_ff        <= pop_hit ? pop_code : reqq_pkg::EV_CW;
         rsp_count_ff       <= fill_ext[reqq_pkg::COUNT_W-1:0];
         rsp_nonempty_ff    <= (fill_in != '0);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_event_valid    = rsp_event_valid_ff;
   assign rsp_event_code     = rsp_code_ff;
   assign rsp_queue_count    = rsp_count_ff;
   assign rsp_queue_nonempty = rsp_nonempty_ff;

endmodule
